FILE: rtl/burst_test_pressure_monitor_defines.svh
// Assertion macros for the burst test pressure monitor.
`ifndef BURST_TEST_PRESSURE_MONITOR_DEFINES_SVH
`define BURST_TEST_PRESSURE_MONITOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BTPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BTPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/btpm_pkg.sv
// Types, constants and helpers shared by the burst test pressure monitor.
`default_nettype none

package btpm_pkg;

    localparam int SEGMENTS   = 9;
    localparam int SEG_W      = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int NTHRESH    = 8;
    localparam int CNT_W      = 4;  // holds 0..NTHRESH

    localparam int ADC_W      = 12;
    localparam int P_W        = 20;
    localparam int SAMP_W     = 6;
    localparam int RATIO_W    = 9;
    localparam int CAL_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam int QUO_W      = 24;
    localparam int DIV_CNT_W  = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

    localparam logic [P_W-1:0] PMAX = {P_W{1'b1}};

    typedef logic [ADC_W-1:0] thresh_arr_t [NTHRESH];
    localparam thresh_arr_t THRESH = '{
        12'd320, 12'd440, 12'd560, 12'd680, 12'd800, 12'd937, 12'd1075, 12'd1220
    };

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;

    localparam logic [2:0] CAUSE_NONE    = 3'd0;
    localparam logic [2:0] CAUSE_BURST   = 3'd1;
    localparam logic [2:0] CAUSE_TIMEOUT = 3'd2;
    localparam logic [2:0] CAUSE_STOP    = 3'd3;
    localparam logic [2:0] CAUSE_BEL_LOW = 3'd4;
    localparam logic [2:0] CAUSE_BEL_HIGH = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_BEL_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BEL_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_P    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO    = 3'd5;

    typedef struct packed {
        logic [1:0]              op;
        logic [ADC_W-1:0]        cup_adc;
        logic [ADC_W-1:0]        bellows_adc;
        logic                    stop_pressed;
        logic [3:0]              segment_index;
        logic signed [CAL_W-1:0] segment_slope;
        logic signed [CAL_W-1:0] segment_offset;
    } in_item_t;

    typedef struct packed {
        logic [SAMP_W-1:0] sample_number;
        logic [P_W-1:0]    pressure_kpa;
        logic              valve_open;
        logic              test_over;
        logic [2:0]        end_cause;
        logic [P_W-1:0]    peak_kpa;
    } out_item_t;

    // Segment = number of thresholds at or below the reading, clamped to the last one.
    function automatic logic [SEG_W-1:0] seg_of(input logic [ADC_W-1:0] adc);
        logic [CNT_W-1:0] cnt;
        cnt = '0;
        for (int i = 0; i < NTHRESH; i++) begin
            if (adc >= THRESH[i]) cnt = cnt + CNT_W'(1);
        end
        if (32'(cnt) > SEGMENTS - 1) cnt = CNT_W'(SEGMENTS - 1);
        return SEG_W'(cnt);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/burst_test_pressure_monitor.sv
// Start, load and other ops go from acceptance straight to ST_FIN, which loads the output register;
// a tick passes ST_CALC, where a zero slope, zero numerator or sign mismatch settles the pressure
// directly, and otherwise ST_DIV, before ST_FIN. One transaction at a time: a tick may run the
// 24-step restoring divider after one calibration memory read.
// A finished result waits in the output register and holds off the next one until taken.
// Reset (aresetn, synchronous, active low): test idle, counters cleared, limits to defaults.
`default_nettype none

`include "burst_test_pressure_monitor_defines.svh"

module burst_test_pressure_monitor (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire btpm_pkg::in_item_t                   s_data,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output btpm_pkg::out_item_t                       m_data,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [btpm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [btpm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CALC = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    btpm_pkg::in_item_t  item_reg, item_next;
    btpm_pkg::out_item_t m_data_reg, m_data_next;
    logic                m_valid_reg, m_valid_next;

    logic [btpm_pkg::ADC_W-1:0]   bel_low_reg, bel_low_next;
    logic [btpm_pkg::ADC_W-1:0]   bel_high_reg, bel_high_next;
    logic [btpm_pkg::SAMP_W-1:0]  timeout_reg, timeout_next;
    logic [btpm_pkg::SAMP_W-1:0]  settle_reg, settle_next;
    logic [btpm_pkg::P_W-1:0]     min_p_reg, min_p_next;
    logic [btpm_pkg::RATIO_W-1:0] ratio_reg, ratio_next;

    logic                         running_reg, running_next;
    logic                         armed_reg, armed_next;
    logic [btpm_pkg::SAMP_W-1:0]  samples_reg, samples_next;
    logic [btpm_pkg::P_W-1:0]     last_p_reg, last_p_next;

    logic [btpm_pkg::P_W-1:0]     p_reg, p_next;
    logic [btpm_pkg::CAL_W-1:0]   den_reg, den_next;
    logic [btpm_pkg::CAL_W-1:0]   rem_reg, rem_next;
    logic [btpm_pkg::QUO_W-1:0]   quo_reg, quo_next;
    logic [btpm_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;

    // Calibration memory: slope in the upper half, offset in the lower half.
    logic [2*btpm_pkg::CAL_W-1:0] cal_mem [btpm_pkg::SEGMENTS];
    logic [2*btpm_pkg::CAL_W-1:0] rd_data_reg;

    logic s_fire;
    logic load_ok;

    // Divider datapath
    logic signed [btpm_pkg::CAL_W-1:0] slope;
    logic signed [btpm_pkg::CAL_W-1:0] offset;
    logic signed [btpm_pkg::CAL_W+1:0] diff;
    logic [btpm_pkg::CAL_W+1:0]        diff_mag;
    logic [btpm_pkg::CAL_W:0]          trial;
    logic                              qbit;
    logic [btpm_pkg::QUO_W-1:0]        quo_shift;

    // Tick evaluation
    logic [btpm_pkg::SAMP_W-1:0]           count;
    logic                                  armed_now;
    logic [btpm_pkg::P_W+btpm_pkg::RATIO_W-1:0] cur_scaled;
    logic [btpm_pkg::P_W+btpm_pkg::RATIO_W-1:0] last_scaled;
    logic [2:0]                            cause;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign load_ok = ({1'b0, s_data.segment_index} < 5'(btpm_pkg::SEGMENTS));

    always_ff @(posedge aclk) begin
        if (s_fire && s_data.op == btpm_pkg::OP_LOAD && load_ok) begin
            cal_mem[s_data.segment_index[btpm_pkg::SEG_W-1:0]] <=
                {s_data.segment_slope, s_data.segment_offset};
        end
        if (s_fire) begin
            rd_data_reg <= cal_mem[btpm_pkg::seg_of(s_data.cup_adc)];
        end
    end

    always_comb begin
        slope    = rd_data_reg[2*btpm_pkg::CAL_W-1:btpm_pkg::CAL_W];
        offset   = rd_data_reg[btpm_pkg::CAL_W-1:0];
        diff     = $signed({6'd0, item_reg.cup_adc}) - $signed({{2{offset[15]}}, offset});
        diff_mag = diff[17] ? 18'(-diff) : 18'(diff);

        trial     = {rem_reg, quo_reg[btpm_pkg::QUO_W-1]};
        qbit      = (trial >= {1'b0, den_reg});
        quo_shift = {quo_reg[btpm_pkg::QUO_W-2:0], qbit};

        count       = samples_reg + btpm_pkg::SAMP_W'(1);
        armed_now   = armed_reg || (p_reg > min_p_reg);
        cur_scaled  = {1'b0, p_reg, 8'd0};
        last_scaled = 29'(last_p_reg) * 29'(ratio_reg);

        if (armed_now && cur_scaled < last_scaled) begin
            cause = btpm_pkg::CAUSE_BURST;
        end else if (count == timeout_reg) begin
            cause = btpm_pkg::CAUSE_TIMEOUT;
        end else if (item_reg.stop_pressed) begin
            cause = btpm_pkg::CAUSE_STOP;
        end else if (count > settle_reg && item_reg.bellows_adc < bel_low_reg) begin
            cause = btpm_pkg::CAUSE_BEL_LOW;
        end else if (count > settle_reg && item_reg.bellows_adc > bel_high_reg) begin
            cause = btpm_pkg::CAUSE_BEL_HIGH;
        end else begin
            cause = btpm_pkg::CAUSE_NONE;
        end
    end

    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg;
        bel_low_next  = bel_low_reg;
        bel_high_next = bel_high_reg;
        timeout_next  = timeout_reg;
        settle_next   = settle_reg;
        min_p_next    = min_p_reg;
        ratio_next    = ratio_reg;
        running_next  = running_reg;
        armed_next    = armed_reg;
        samples_next  = samples_reg;
        last_p_next   = last_p_reg;
        p_next        = p_reg;
        den_next      = den_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        cnt_next      = cnt_reg;

        if (cfg_wr_en) begin
            case (cfg_index)
                btpm_pkg::REG_BEL_LOW:  bel_low_next  = cfg_wdata[btpm_pkg::ADC_W-1:0];
                btpm_pkg::REG_BEL_HIGH: bel_high_next = cfg_wdata[btpm_pkg::ADC_W-1:0];
                btpm_pkg::REG_TIMEOUT:  timeout_next  = cfg_wdata[btpm_pkg::SAMP_W-1:0];
                btpm_pkg::REG_SETTLE:   settle_next   = cfg_wdata[btpm_pkg::SAMP_W-1:0];
                btpm_pkg::REG_MIN_P:    min_p_next    = cfg_wdata[btpm_pkg::P_W-1:0];
                btpm_pkg::REG_RATIO:    ratio_next    = cfg_wdata[btpm_pkg::RATIO_W-1:0];
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = (s_data.op == btpm_pkg::OP_TICK) ? ST_CALC : ST_FIN;
                end
            end
            ST_CALC: begin
                // Settle the sign and zero cases here; only real quotients use the divider.
                if (slope == '0) begin
                    p_next     = btpm_pkg::PMAX;
                    state_next = ST_FIN;
                end else if (diff == '0 || diff[17] != slope[15]) begin
                    p_next     = '0;
                    state_next = ST_FIN;
                end else begin
                    den_next   = slope[15] ? (~slope + 16'sd1) : slope;
                    rem_next   = '0;
                    quo_next   = {diff_mag[btpm_pkg::CAL_W-1:0], 8'd0};
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next = qbit ? btpm_pkg::CAL_W'(trial - {1'b0, den_reg})
                                : trial[btpm_pkg::CAL_W-1:0];
                quo_next = quo_shift;
                cnt_next = cnt_reg + btpm_pkg::DIV_CNT_W'(1);
                if (cnt_reg == btpm_pkg::DIV_LAST) begin
                    p_next = (quo_shift[btpm_pkg::QUO_W-1:btpm_pkg::P_W] != '0)
                             ? btpm_pkg::PMAX : quo_shift[btpm_pkg::P_W-1:0];
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                // Hold until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    m_data_next  = '0;
                    case (item_reg.op)
                        btpm_pkg::OP_START: begin
                            running_next           = 1'b1;
                            armed_next             = 1'b0;
                            samples_next           = '0;
                            last_p_next            = '0;
                            m_data_next.valve_open = 1'b1;
                        end
                        btpm_pkg::OP_TICK: begin
                            m_data_next.sample_number = samples_reg;
                            m_data_next.pressure_kpa  = p_reg;
                            if (running_reg) begin
                                samples_next = count;
                                armed_next   = armed_now;
                                last_p_next  = p_reg;
                                running_next = (cause == btpm_pkg::CAUSE_NONE);
                                m_data_next.valve_open = (cause == btpm_pkg::CAUSE_NONE);
                                m_data_next.test_over  = (cause != btpm_pkg::CAUSE_NONE);
                                m_data_next.end_cause  = cause;
                                if (cause == btpm_pkg::CAUSE_BURST) begin
                                    m_data_next.peak_kpa = last_p_reg;
                                end
                            end
                        end
                        default: begin
                            m_data_next.sample_number = samples_reg;
                            m_data_next.valve_open    = running_reg;
                        end
                    endcase
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            bel_low_reg  <= '0;
            bel_high_reg <= 12'd4095;
            timeout_reg  <= 6'd30;
            settle_reg   <= 6'd2;
            min_p_reg    <= 20'd26;
            ratio_reg    <= 9'd154;
            running_reg  <= 1'b0;
            armed_reg    <= 1'b0;
            samples_reg  <= '0;
            last_p_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            bel_low_reg  <= bel_low_next;
            bel_high_reg <= bel_high_next;
            timeout_reg  <= timeout_next;
            settle_reg   <= settle_next;
            min_p_reg    <= min_p_next;
            ratio_reg    <= ratio_next;
            running_reg  <= running_next;
            armed_reg    <= armed_next;
            samples_reg  <= samples_next;
            last_p_reg   <= last_p_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        m_data_reg <= m_data_next;
        p_reg      <= p_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
    end

    `BTPM_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_fire, !s_ready, "accepted while busy")
    `BTPM_ASSERT_NOW(a_over_closes_valve, aclk, aresetn, m_valid && m_data.test_over, !m_data.valve_open, "valve open at test end")
    `BTPM_ASSERT_NOW(a_cause_matches_over, aclk, aresetn, m_valid, m_data.test_over == (m_data.end_cause != btpm_pkg::CAUSE_NONE), "end cause and test_over disagree")
    `BTPM_ASSERT_NOW(a_peak_only_on_burst, aclk, aresetn, m_valid && m_data.end_cause != btpm_pkg::CAUSE_BURST, m_data.peak_kpa == '0, "peak reported without burst")

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for the burst test pressure monitor: directed table, then random test runs.
`timescale 1ns / 100ps

module tb_top;
    import btpm_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 130;
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_ORDER [6] = '{
        REG_BEL_LOW, REG_BEL_HIGH, REG_TIMEOUT, REG_SETTLE, REG_MIN_P, REG_RATIO
    };

    localparam out_item_t REST_ZERO = '0;
    localparam out_item_t IDLE_SAT  = '{pressure_kpa: PMAX, default: '0};
    localparam out_item_t STARTED   = '{valve_open: 1'b1, default: '0};

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } step_row_t;

    typedef struct {
        int regs [6];
        int send_pct;
        int stall_pct;
    } phase_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Predictor copy of the block state and limits
    bit               test_running = 1'b0;
    bit               burst_armed  = 1'b0;
    logic [SAMP_W-1:0] sample_count = '0;
    logic [P_W-1:0]   prev_kpa     = '0;
    int               cal_slope  [SEGMENTS];
    int               cal_offset [SEGMENTS];
    logic [ADC_W-1:0] lim_low      = 12'd0;
    logic [ADC_W-1:0] lim_high     = 12'd4095;
    logic [SAMP_W-1:0] timeout_cnt = 6'd30;
    logic [SAMP_W-1:0] settle_cnt  = 6'd2;
    logic [P_W-1:0]   arm_level    = 20'd26;
    logic [RATIO_W-1:0] drop_frac  = 9'd154;

    out_item_t pending_readings [$];
    step_row_t directed_rows [$];
    phase_t    phases [5];
    int        mismatch_count = 0;
    int        quiet_cycles   = 0;
    int        items_sent     = 0;
    int        send_pct       = 0;
    int        stall_pct      = 0;

    burst_test_pressure_monitor DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: %s got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic in_item_t make_item(input logic [1:0] op, input int cup, input int bel,
                                           input int stop, input int idx, input int slope,
                                           input int off);
        in_item_t it;
        it.op             = op;
        it.cup_adc        = cup[ADC_W-1:0];
        it.bellows_adc    = bel[ADC_W-1:0];
        it.stop_pressed   = stop[0];
        it.segment_index  = idx[3:0];
        it.segment_slope  = slope[CAL_W-1:0];
        it.segment_offset = off[CAL_W-1:0];
        return it;
    endfunction

    function automatic step_row_t row(input in_item_t it, input bit typed = 1'b0,
                                      input out_item_t want = '0);
        step_row_t r;
        r.item  = it;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    function automatic logic [P_W-1:0] calibrated_kpa(input logic [ADC_W-1:0] adc);
        int     seg;
        int     slope;
        longint diff;
        longint num;
        longint q;
        seg = 0;
        for (int i = 0; i < NTHRESH; i++) begin
            if (adc >= THRESH[i]) seg++;
        end
        if (seg > SEGMENTS - 1) seg = SEGMENTS - 1;
        slope = cal_slope[seg];
        diff  = longint'(adc) - longint'(cal_offset[seg]);
        if (slope == 0) return PMAX;
        if (diff == 0) return '0;
        if ((diff < 0) != (slope < 0)) return '0;
        num = (diff < 0 ? -diff : diff) << 8;
        q   = num / longint'(slope < 0 ? -slope : slope);
        return (q > longint'(PMAX)) ? PMAX : q[P_W-1:0];
    endfunction

    function automatic out_item_t predict_reading(input in_item_t it);
        out_item_t         r;
        logic [P_W-1:0]    kpa;
        logic [SAMP_W-1:0] next_count;
        logic [2:0]        cause;
        r = '0;
        r.sample_number = sample_count;
        r.valve_open    = test_running;
        case (it.op)
            OP_START: begin
                test_running    = 1'b1;
                burst_armed     = 1'b0;
                sample_count    = '0;
                prev_kpa        = '0;
                r.sample_number = '0;
                r.valve_open    = 1'b1;
            end
            OP_TICK: begin
                kpa            = calibrated_kpa(it.cup_adc);
                r.pressure_kpa = kpa;
                if (test_running) begin
                    next_count   = sample_count + 6'd1;
                    sample_count = next_count;
                    cause        = CAUSE_NONE;
                    if (kpa > arm_level) burst_armed = 1'b1;
                    if (burst_armed && 64'(kpa) * 64'd256 < 64'(prev_kpa) * 64'(drop_frac)) begin
                        cause     = CAUSE_BURST;
                        r.peak_kpa = prev_kpa;
                    end else if (next_count == timeout_cnt) begin
                        cause = CAUSE_TIMEOUT;
                    end else if (it.stop_pressed) begin
                        cause = CAUSE_STOP;
                    end else if (next_count > settle_cnt && it.bellows_adc < lim_low) begin
                        cause = CAUSE_BEL_LOW;
                    end else if (next_count > settle_cnt && it.bellows_adc > lim_high) begin
                        cause = CAUSE_BEL_HIGH;
                    end
                    prev_kpa = kpa;
                    if (cause != CAUSE_NONE) test_running = 1'b0;
                    r.valve_open = test_running;
                    r.test_over  = (cause != CAUSE_NONE);
                    r.end_cause  = cause;
                end
            end
            OP_LOAD: begin
                if (it.segment_index < SEGMENTS) begin
                    cal_slope[it.segment_index]  = int'($signed(it.segment_slope));
                    cal_offset[it.segment_index] = int'($signed(it.segment_offset));
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Hold valid until the transaction is taken, then queue what it should produce.
    task automatic drive_item(input in_item_t it, input bit typed = 1'b0,
                              input out_item_t want = '0);
        out_item_t predicted;
        if (send_pct != 0 && $urandom_range(99) < send_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_pct);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_reading(it);
        pending_readings.push_back(typed ? want : predicted);
        if (it.op != OP_SPARE && !(it.op == OP_LOAD && it.segment_index >= SEGMENTS))
            items_sent++;
    endtask

    task automatic drain_readings();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_readings.size() != 0);
    endtask

    task automatic program_limits(input int vals [6]);
        for (int i = 0; i < 6; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= REG_ORDER[i];
            cfg_wdata <= vals[i][CFG_DATA_W-1:0];
            @(posedge aclk);
            case (REG_ORDER[i])
                REG_BEL_LOW:  lim_low     = vals[i][ADC_W-1:0];
                REG_BEL_HIGH: lim_high    = vals[i][ADC_W-1:0];
                REG_TIMEOUT:  timeout_cnt = vals[i][SAMP_W-1:0];
                REG_SETTLE:   settle_cnt  = vals[i][SAMP_W-1:0];
                REG_MIN_P:    arm_level   = vals[i][P_W-1:0];
                REG_RATIO:    drop_frac   = vals[i][RATIO_W-1:0];
                default: ;
            endcase
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Reload one or all segments with slopes that give usable pressures.
    task automatic load_calibration();
        int first_seg;
        int last_seg;
        int slope;
        int off;
        first_seg = 0;
        last_seg  = SEGMENTS - 1;
        if ($urandom_range(3) == 0) begin
            first_seg = $urandom_range(SEGMENTS - 1);
            last_seg  = first_seg;
        end
        for (int seg = first_seg; seg <= last_seg; seg++) begin
            if ($urandom_range(3) == 0) begin
                slope = -int'($urandom_range(1, 24));
                off   = $urandom_range(4100, 8000);
            end else begin
                slope = $urandom_range(1, 24);
                off   = $urandom_range(0, 250);
            end
            drive_item(make_item(OP_LOAD, $urandom, $urandom, $urandom, seg, slope, off));
        end
    endtask

    // One test: start, then a rising specimen reading with an occasional sharp drop.
    task automatic run_test();
        int run_len;
        int cup;
        int bel;
        drive_item(make_item(OP_START, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom));
        run_len = (timeout_cnt == 0) ? $urandom_range(50, 70) : $urandom_range(1, 45);
        cup     = $urandom_range(250, 700);
        for (int k = 0; k < run_len; k++) begin
            if ($urandom_range(99) < 6)
                cup = $urandom_range(0, cup / 3);
            else
                cup = cup + $urandom_range(0, 60);
            if (cup > 4095) cup = 4095;
            if ($urandom_range(99) < 4 || lim_low > lim_high)
                bel = $urandom_range(4095);
            else
                bel = $urandom_range(lim_high, lim_low);
            drive_item(make_item(OP_TICK, cup, bel, ($urandom_range(199) == 0), $urandom,
                                 $urandom, $urandom));
            if (!test_running && $urandom_range(99) < 80) break;
        end
    endtask

    task automatic run_phase(input int budget);
        int       first_count;
        int       pick;
        logic [63:0] raw;
        first_count = items_sent;
        while (items_sent - first_count < budget) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                raw = {$urandom, $urandom};
                drive_item(in_item_t'(raw[62:0]));
            end else if (pick < 14) begin
                load_calibration();
            end else if (pick < 18) begin
                drain_readings();
            end else begin
                run_test();
            end
        end
    endtask

    always @(posedge aclk) begin : check_results
        out_item_t exp_r;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_readings.size() == 0) begin
                    report_mismatch("unexpected result, sample_number", m_data.sample_number, -1);
                end else begin
                    exp_r = pending_readings.pop_front();
                    if (m_data.sample_number !== exp_r.sample_number)
                        report_mismatch("sample_number", m_data.sample_number,
                                        exp_r.sample_number);
                    if (m_data.pressure_kpa !== exp_r.pressure_kpa)
                        report_mismatch("pressure_kpa", m_data.pressure_kpa, exp_r.pressure_kpa);
                    if (m_data.valve_open !== exp_r.valve_open)
                        report_mismatch("valve_open", m_data.valve_open, exp_r.valve_open);
                    if (m_data.test_over !== exp_r.test_over)
                        report_mismatch("test_over", m_data.test_over, exp_r.test_over);
                    if (m_data.end_cause !== exp_r.end_cause)
                        report_mismatch("end_cause", m_data.end_cause, exp_r.end_cause);
                    if (m_data.peak_kpa !== exp_r.peak_kpa)
                        report_mismatch("peak_kpa", m_data.peak_kpa, exp_r.peak_kpa);
                end
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
        if ((m_valid && m_ready) || (s_valid && s_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("burst_test_pressure_monitor: mismatch");
        $finish;
    end

    initial begin : stimulus
        phases[0] = '{regs: '{0, 4095, 63, 0, 0, 256},         send_pct: 0,  stall_pct: 0};
        phases[1] = '{regs: '{1000, 3000, 20, 5, 5000, 154},   send_pct: 86, stall_pct: 0};
        phases[2] = '{regs: '{4095, 0, 1, 63, 1048575, 0},     send_pct: 0,  stall_pct: 86};
        phases[3] = '{regs: '{0, 4095, 0, 2, 26, 0},           send_pct: 37, stall_pct: 37};
        phases[4] = '{regs: '{200, 3900, 30, 10, 26, 200},     send_pct: 0,  stall_pct: 0};

        // Segment 0 has a zero slope, segment 1 overflows, segment 3 is doubly negative.
        directed_rows.push_back(row(make_item(OP_LOAD, 0, 0, 0, 0, 0, 0), 1'b1, REST_ZERO));
        directed_rows.push_back(row(make_item(OP_LOAD, 4095, 4095, 1, 1, 1, -32768),
                                    1'b1, REST_ZERO));
        directed_rows.push_back(row(make_item(OP_LOAD, 0, 0, 0, 2, 4, 400), 1'b1, REST_ZERO));
        directed_rows.push_back(row(make_item(OP_LOAD, 0, 0, 0, 3, -32768, 32767),
                                    1'b1, REST_ZERO));
        directed_rows.push_back(row(make_item(OP_LOAD, 0, 0, 0, 4, 32767, 700),
                                    1'b1, REST_ZERO));
        directed_rows.push_back(row(make_item(OP_LOAD, 0, 0, 0, 5, 2, 900), 1'b1, REST_ZERO));
        directed_rows.push_back(row(make_item(OP_LOAD, 0, 0, 0, 6, 3, 0), 1'b1, REST_ZERO));
        directed_rows.push_back(row(make_item(OP_LOAD, 0, 0, 0, 7, 1, 1000), 1'b1, REST_ZERO));
        directed_rows.push_back(row(make_item(OP_LOAD, 0, 0, 0, 8, 8, 1220), 1'b1, REST_ZERO));
        // Out-of-range segment load and the spare op leave everything alone.
        directed_rows.push_back(row(make_item(OP_LOAD, 0, 0, 0, 15, 32767, -32768),
                                    1'b1, REST_ZERO));
        directed_rows.push_back(row(make_item(OP_SPARE, 4095, 4095, 1, 15, -1, -1),
                                    1'b1, REST_ZERO));
        directed_rows.push_back(row(make_item(OP_TICK, 0, 2048, 0, 0, 0, 0), 1'b1, IDLE_SAT));
        directed_rows.push_back(row(make_item(OP_TICK, 320, 2048, 0, 0, 0, 0), 1'b1, IDLE_SAT));
        directed_rows.push_back(row(make_item(OP_TICK, 4095, 2048, 0, 0, 0, 0)));
        directed_rows.push_back(row(make_item(OP_START, 0, 0, 0, 0, 0, 0), 1'b1, STARTED));
        directed_rows.push_back(row(make_item(OP_TICK, 500, 2048, 0, 0, 0, 0)));
        directed_rows.push_back(row(make_item(OP_TICK, 1100, 2048, 0, 0, 0, 0)));
        // Threshold pair at 936/937 splits correctly; the drop is a burst.
        directed_rows.push_back(row(make_item(OP_TICK, 937, 2048, 0, 0, 0, 0)));
        directed_rows.push_back(row(make_item(OP_TICK, 936, 2048, 0, 0, 0, 0)));
        directed_rows.push_back(row(make_item(OP_START, 0, 0, 0, 0, 0, 0), 1'b1, STARTED));
        directed_rows.push_back(row(make_item(OP_TICK, 800, 2048, 0, 0, 0, 0)));
        directed_rows.push_back(row(make_item(OP_TICK, 1219, 2048, 0, 0, 0, 0)));
        // Burst and user stop together: burst wins.
        directed_rows.push_back(row(make_item(OP_TICK, 700, 2048, 1, 0, 0, 0)));
        directed_rows.push_back(row(make_item(OP_START, 0, 0, 0, 0, 0, 0), 1'b1, STARTED));
        directed_rows.push_back(row(make_item(OP_TICK, 680, 2048, 0, 0, 0, 0)));
        directed_rows.push_back(row(make_item(OP_START, 0, 0, 0, 0, 0, 0), 1'b1, STARTED));
        directed_rows.push_back(row(make_item(OP_TICK, 560, 2048, 1, 0, 0, 0)));
        directed_rows.push_back(row(make_item(OP_TICK, 440, 2048, 0, 0, 0, 0)));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            drive_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        drain_readings();

        foreach (phases[p]) begin
            program_limits(phases[p].regs);
            send_pct  = phases[p].send_pct;
            stall_pct = phases[p].stall_pct;
            run_phase(PHASE_ITEMS);
            drain_readings();
        end

        // Catch any stray result after the last expected one.
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0)
            $display("burst_test_pressure_monitor: match");
        else
            $display("burst_test_pressure_monitor: mismatch");
        $finish;
    end

endmodule
